@@ hw/rtl/hub75_bit_plane_packer_assert.svh @@
// assertion macros for the hub75 bit plane packer
// included by modules that check their own control logic; no other dependencies
`ifndef HUB75_BIT_PLANE_PACKER_ASSERT_SVH
`define HUB75_BIT_PLANE_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define HUB75_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HUB75_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HUB75_ASSERT(label, clk, rst_n, prop, msg)
`define HUB75_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/hub75_bpp_pkg.sv @@
// shared types and constants for the hub75 bit plane packer
// no dependencies
`timescale 1ns / 1ps
package hub75_bpp_pkg;

    localparam int unsigned MATRIX_WIDTH = 64;
    localparam int unsigned SCAN_ROWS    = 16;
    localparam int unsigned STORE_DEPTH  = 2048;
    localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
    localparam int unsigned HALF_OFFSET  = MATRIX_WIDTH * SCAN_ROWS;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] plane;
    } rd_ctrl_t;

endpackage

@@ hw/rtl/hub75_bpp_frame_store.sv @@
// frame memory: one write port, two registered read ports
// depends on hub75_bpp_pkg
`timescale 1ns / 1ps
module hub75_bpp_frame_store
    import hub75_bpp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_up,
    input  logic [ADDR_W-1:0] rd_addr_lo,
    output pixel_t            rd_data_up,
    output pixel_t            rd_data_lo
);

    pixel_t mem [STORE_DEPTH];
    pixel_t rd_up_reg;
    pixel_t rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_up_reg <= mem[rd_addr_up];
            rd_lo_reg <= mem[rd_addr_lo];
        end
    end

    assign rd_data_up = rd_up_reg;
    assign rd_data_lo = rd_lo_reg;

endmodule

@@ hw/rtl/hub75_bpp_out_stage.sv @@
// bit plane extraction and output register of the drive word channel
// depends on hub75_bpp_pkg
`timescale 1ns / 1ps
module hub75_bpp_out_stage
    import hub75_bpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rd_ctrl_t   ctrl,
    input  pixel_t     px_up,
    input  pixel_t     px_lo,
    output logic       take,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // drive_word [5:0], zero [7:6]
);

    logic       valid_reg;
    logic       valid_next;
    logic [5:0] word_reg;
    logic [5:0] word_next;

    always_comb
    begin
        take       = !valid_reg || m_tready;
        valid_next = valid_reg;
        word_next  = word_reg;
        if (take)
        begin
            valid_next = ctrl.valid;
            word_next  = {px_lo.red[ctrl.plane], px_lo.green[ctrl.plane],
                          px_lo.blue[ctrl.plane], px_up.red[ctrl.plane],
                          px_up.green[ctrl.plane], px_up.blue[ctrl.plane]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, word_reg};

endmodule

@@ hw/rtl/hub75_bit_plane_packer.sv @@
// top level of the hub75 bit plane packer: frame store plus drive word lookup
// depends on hub75_bpp_pkg, hub75_bpp_frame_store, hub75_bpp_out_stage,
// hub75_bit_plane_packer_assert.svh
//
// usage
// the slave channel takes one word per cycle while s_tready is high; tuser selects the kind:
// a write word stores red, green and blue at pixel_index and gives no result,
// a read word names scan_row, bit_plane and column and gives one drive word
// on the master channel: lower-half pixel bits in 5..3, upper-half in 2..0
// the lower-half pixel lies MATRIX_WIDTH * SCAN_ROWS entries past the upper
// throughput is one word per cycle for any mix of reads and writes while the receiver
// does not stall, set by the frame memory with two read ports and one write port
// a read passes the memory read register, then the output register
// a read right after a write to the same pixel sees the new data
// when the receiver stalls, the output register and the read stage hold,
// s_tready drops only while both are full
// reset clears the pipeline valid bits; the frame store is not cleared and
// pixels must be written before they are read
`timescale 1ns / 1ps
`include "hub75_bit_plane_packer_assert.svh"
module hub75_bit_plane_packer
    import hub75_bpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_index, red_in, green_in, blue_in,
                                   // scan_row, bit_plane, column
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // drive_word, zero padding
);

    logic [10:0]       pixel_index;
    pixel_t            wr_px;
    logic [3:0]        scan_row;
    logic [2:0]        bit_plane;
    logic [5:0]        column;
    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr_up;
    logic [ADDR_W-1:0] addr_lo;
    pixel_t            px_up;
    pixel_t            px_lo;
    logic              take;
    rd_ctrl_t          s1_reg;
    rd_ctrl_t          s1_next;

    assign pixel_index = s_tdata[10:0];
    assign wr_px.red   = s_tdata[18:11];
    assign wr_px.green = s_tdata[26:19];
    assign wr_px.blue  = s_tdata[34:27];
    assign scan_row    = s_tdata[38:35];
    assign bit_plane   = s_tdata[41:39];
    assign column      = s_tdata[47:42];

    assign s_tready = !s1_reg.valid || take;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == OP_WRITE);
    assign rd_en    = accept && (s_tuser == OP_READ);

    assign addr_up = ADDR_W'(32'(scan_row) * MATRIX_WIDTH + 32'(column));
    assign addr_lo = ADDR_W'(32'(addr_up) + HALF_OFFSET);

    always_comb
    begin
        s1_next = s1_reg;
        if (s_tready)
        begin
            s1_next.valid = rd_en;
            s1_next.plane = bit_plane;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid <= 1'b0;
            s1_reg.plane <= 3'd0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    hub75_bpp_frame_store u_store
    (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (ADDR_W'(pixel_index)),
        .wr_data    (wr_px),
        .rd_en      (rd_en),
        .rd_addr_up (addr_up),
        .rd_addr_lo (addr_lo),
        .rd_data_up (px_up),
        .rd_data_lo (px_lo)
    );

    hub75_bpp_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (s1_reg),
        .px_up    (px_up),
        .px_lo    (px_lo),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `HUB75_ASSERT(a_stall_cause, clk, rst_n, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    `HUB75_ASSERT(a_read_enters, clk, rst_n, (s_tvalid && s_tready && s_tuser == OP_READ) |=> s1_reg.valid, "accepted read lost before memory stage")
    `HUB75_ASSERT(a_write_silent, clk, rst_n, (s_tvalid && s_tready && s_tuser == OP_WRITE) |=> !s1_reg.valid, "write produced a read stage entry")
    `HUB75_ASSERT_ALWAYS(a_pad_zero, clk, m_tdata[7:6] == 2'b00, "drive word padding not zero")

endmodule

@@ tb/tb_hub75_bit_plane_packer.sv @@
// self-checking testbench for hub75_bit_plane_packer: pixel writes and drive word reads
// on the stream ports, checked against an in-bench copy of the frame store
// depends on hub75_bpp_pkg and the hub75_bit_plane_packer rtl
`timescale 1ns / 1ps
module tb_hub75_bit_plane_packer;
    import hub75_bpp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pixel_index, red_in, green_in, blue_in, scan_row, bit_plane, column
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // drive_word, zero padding

    hub75_bit_plane_packer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pixel_t     frame_copy [STORE_DEPTH];
    bit         pixel_written [STORE_DEPTH];
    logic [5:0] drive_words_due [$];
    logic [5:0] due_word;

    int errors;
    int words_checked;
    int writes_sent;
    int reads_sent;
    int gap_max;
    int burst_left;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [3:0] row,
                                                      input logic [5:0] col,
                                                      input bit lower_half);
        int unsigned a;
        a = row * MATRIX_WIDTH + col;
        if (lower_half)
            a = a + HALF_OFFSET;
        return ADDR_W'(a);
    endfunction

    function automatic logic [5:0] predict_drive_word(input logic [3:0] row,
                                                      input logic [2:0] plane,
                                                      input logic [5:0] col);
        pixel_t up;
        pixel_t lo;
        up = frame_copy[pixel_addr(row, col, 1'b0)];
        lo = frame_copy[pixel_addr(row, col, 1'b1)];
        return {lo.red[plane], lo.green[plane], lo.blue[plane],
                up.red[plane], up.green[plane], up.blue[plane]};
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return pixel_t'(24'($urandom));
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [ADDR_W-1:0] idx, input pixel_t px,
                             input logic [3:0] row, input logic [2:0] plane,
                             input logic [5:0] col);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, plane, row, px.blue, px.green, px.red, idx};
        do @(posedge clk); while (!s_tready);
        if (op == OP_WRITE)
        begin
            frame_copy[idx] = px;
            pixel_written[idx] = 1'b1;
            writes_sent++;
        end
        else
        begin
            drive_words_due.push_back(predict_drive_word(row, plane, col));
            reads_sent++;
        end
    endtask

    task automatic write_pixel(input logic [ADDR_W-1:0] idx, input pixel_t px);
        send_word(OP_WRITE, idx, px, 4'($urandom), 3'($urandom), 6'($urandom));
    endtask

    task automatic ensure_written(input logic [ADDR_W-1:0] idx);
        if (!pixel_written[idx])
            write_pixel(idx, random_pixel());
    endtask

    // both halves must hold data before a read
    task automatic read_word(input logic [3:0] row, input logic [2:0] plane,
                             input logic [5:0] col);
        ensure_written(pixel_addr(row, col, 1'b0));
        ensure_written(pixel_addr(row, col, 1'b1));
        send_word(OP_READ, ADDR_W'($urandom), pixel_t'(24'($urandom)), row, plane, col);
    endtask

    task automatic wait_for_drive_words();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (drive_words_due.size() != 0);
    endtask

    task automatic test_directed();
        int p;
        gap_max = 0;
        write_pixel(ADDR_W'(0), '1);
        write_pixel(ADDR_W'(HALF_OFFSET), '0);
        read_word(4'd0, 3'd0, 6'd0);
        read_word(4'd0, 3'd7, 6'd0);
        write_pixel(ADDR_W'(HALF_OFFSET - 1), {8'h80, 8'h01, 8'hAA});
        write_pixel(ADDR_W'(STORE_DEPTH - 1), {8'h55, 8'hFE, 8'h7F});
        for (p = 0; p < 8; p++)
            read_word(4'd15, 3'(p), 6'd63);
        // reads right behind writes to the same pixel, upper then lower half
        write_pixel(ADDR_W'(0), {8'h12, 8'h34, 8'h56});
        read_word(4'd0, 3'd1, 6'd0);
        write_pixel(ADDR_W'(HALF_OFFSET), {8'hFF, 8'h00, 8'hFF});
        read_word(4'd0, 3'd4, 6'd0);
        write_pixel(ADDR_W'(STORE_DEPTH - 1), '0);
        read_word(4'd15, 3'd6, 6'd63);
        wait_for_drive_words();
    endtask

    task automatic test_random_traffic(input int n, input int gmax);
        int start;
        logic [3:0] row;
        logic [5:0] col;
        bit lower;
        gap_max = gmax;
        start = writes_sent + reads_sent;
        while (writes_sent + reads_sent - start < n)
        begin
            row = 4'($urandom);
            col = 6'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    read_word(row, 3'($urandom), col);
                9, 10, 11, 12, 13:
                    write_pixel(ADDR_W'($urandom), random_pixel());
                14, 15, 16, 17:
                begin
                    lower = 1'($urandom_range(0, 1));
                    ensure_written(pixel_addr(row, col, !lower));
                    write_pixel(pixel_addr(row, col, lower), random_pixel());
                    read_word(row, 3'($urandom), col);
                end
                default:
                begin
                    // small hot set so writes and reads keep hitting the same pixels
                    row = 4'($urandom_range(0, 1));
                    col = 6'($urandom_range(0, 3));
                    if ($urandom_range(0, 1))
                        write_pixel(pixel_addr(row, col, 1'($urandom_range(0, 1))),
                                    random_pixel());
                    read_word(row, 3'($urandom), col);
                end
            endcase
        end
        wait_for_drive_words();
    endtask

    task automatic test_receiver_hold_off();
        int i;
        gap_max = 0;
        hold_left = 400;
        for (i = 0; i < 60; i++)
            read_word(4'($urandom), 3'($urandom), 6'($urandom));
        wait_for_drive_words();
    endtask

    // receiver: random stall modes, plus long hold-offs on request
    initial
    begin
        int rx_mode;
        int mode_left;
        int cyc;
        rx_mode = 0;
        mode_left = 0;
        cyc = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (cyc % 7) < 4;
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_words_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected drive word, expected none, actual %h",
                         $time, m_tdata[5:0]);
            end
            else
            begin
                due_word = drive_words_due.pop_front();
                words_checked++;
                if (m_tdata[5:0] !== due_word)
                begin
                    errors++;
                    $display("%0t: drive_word mismatch, expected %h, actual %h",
                             $time, due_word, m_tdata[5:0]);
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        words_checked = 0;
        writes_sent = 0;
        reads_sent = 0;
        gap_max = 0;
        burst_left = 0;
        hold_left = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            pixel_written[i] = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_WRITE;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(540, 0);
        test_receiver_hold_off();
        test_random_traffic(540, 6);
        test_random_traffic(540, 20);

        wait_for_drive_words();
        repeat (8) @(posedge clk);
        $display("run covered %0d pixel writes and %0d drive word reads, %0d words checked",
                 writes_sent, reads_sent, words_checked);
        $display("including a 400 cycle receiver hold-off and idle gaps from none up to 20 cycles");
        if (errors == 0 && drive_words_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/hub75_bpp_pkg.sv
hw/rtl/hub75_bpp_frame_store.sv
hw/rtl/hub75_bpp_out_stage.sv
hw/rtl/hub75_bit_plane_packer.sv
tb/tb_hub75_bit_plane_packer.sv
